/* sv/pgr_pkg.sv */
// ----------------------------------------------------------------------------
// pgr_pkg
// Shared widths, register indexes and result codes of the pinch recognizer.
// ----------------------------------------------------------------------------
package pgr_pkg;

  // Positions in cm carry 12 fraction bits and fit 20 bits.
  localparam int CM_W     = 20;
  localparam int DIFF_W   = CM_W + 1;
  localparam int SQ_IN_W  = 2 * DIFF_W;
  localparam int GAP_W    = DIFF_W;
  localparam int SQ_ITERS = SQ_IN_W / 2;
  localparam int MUL_W    = 22;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ACC_W    = 60;
  localparam int MAG_W    = 42;
  localparam int HALF_W   = 18;
  localparam int POS_SHIFT = 4;

  localparam logic [2:0] REG_PAD_WIDTH  = 3'd0;
  localparam logic [2:0] REG_PAD_HEIGHT = 3'd1;
  localparam logic [2:0] REG_GAP_MIN    = 3'd2;
  localparam logic [2:0] REG_MOVE_MIN   = 3'd3;
  localparam logic [2:0] REG_DIR_COS    = 3'd4;

  localparam logic [1:0] GS_START  = 2'd0;
  localparam logic [1:0] GS_RUN    = 2'd1;
  localparam logic [1:0] GS_END    = 2'd2;
  localparam logic [1:0] GS_CANCEL = 2'd3;

  localparam logic [15:0] RATIO_MAX = 16'hFFFF;

  typedef logic [CM_W-1:0] cm_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

endpackage

/* sv/pinch_gesture_recognizer.sv */
// ----------------------------------------------------------------------------
// pinch_gesture_recognizer
// Two-finger pinch detection with a Q8.8 gap ratio, built around one shared
// multiplier-accumulator and one iterative square-root / divide unit.
// ----------------------------------------------------------------------------
// Usage: one transaction on the in_ channel carries a touch frame. The block
// drops in_ready while it works on that frame, then returns to ready. A frame
// gives zero or one transaction on the out_ channel (state and gap ratio).
// Steps: the coordinates are converted to cm on the shared multiplier, then
// the current gap is computed through the square-root unit. A running pinch
// adds a restoring division and an emit step; an idle frame that tests for a
// start adds the axis length, two motion tests, the gap test, the division
// and the emit. in_ready stays low until the frame is done, so the block
// takes no new frame before it is through with the last one; its pace is
// set by the bit-per-cycle sqrt/divide unit.
// The result sits in an output register; when the receiver stalls, the block
// still takes the next frame and stops at emit while that result is pending.
// Reset (synchronous, rst_n low) restores the register defaults, clears the
// touch history and leaves the recognizer idle with no pending result.
// Users must write registers through the APB port only while the block is idle; it does not enforce this.
// ----------------------------------------------------------------------------
module pinch_gesture_recognizer
  import pgr_pkg::*;
#(
  parameter int COORD_BITS      = 12,
  parameter int RATIO_FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_first_x,
  input  logic [COORD_BITS-1:0] in_first_y,
  input  logic [COORD_BITS-1:0] in_second_x,
  input  logic [COORD_BITS-1:0] in_second_y,
  input  logic                  in_first_valid,
  input  logic                  in_second_valid,
  input  logic                  in_touch_owned,
  input  logic                  in_cancel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_gesture_state,
  output logic [15:0]           out_gap_ratio_q8,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int CONV_SHIFT = COORD_BITS - 4;
  localparam int DIV_W      = GAP_W + RATIO_FRAC_BITS;
  localparam int K_W        = $clog2(DIV_W + 1);
  localparam logic [15:0] RATIO_ONE = 16'(1 << RATIO_FRAC_BITS);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CONV   = 4'd1;
  localparam logic [3:0] ST_GAP_SQ = 4'd2;
  localparam logic [3:0] ST_GAP_RT = 4'd3;
  localparam logic [3:0] ST_F_SQ   = 4'd4;
  localparam logic [3:0] ST_F_RT   = 4'd5;
  localparam logic [3:0] ST_M_SQ   = 4'd6;
  localparam logic [3:0] ST_M_CHK  = 4'd7;
  localparam logic [3:0] ST_M_RT   = 4'd8;
  localparam logic [3:0] ST_DOT    = 4'd9;
  localparam logic [3:0] ST_RHS    = 4'd10;
  localparam logic [3:0] ST_CMP    = 4'd11;
  localparam logic [3:0] ST_DIFF   = 4'd12;
  localparam logic [3:0] ST_DIV    = 4'd13;
  localparam logic [3:0] ST_EMIT   = 4'd14;

  // Configuration
  logic [15:0] pad_w_r, pad_h_r, gap_min_r, move_min_r;
  logic [14:0] dir_cos_r;
  logic        wr_en;

  // Control
  logic [3:0]     state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic           phase_r, phase_nxt;
  logic           touch_r, touch_nxt;
  logic [1:0]     prev_valid_r;

  // Frame and history
  logic [COORD_BITS-1:0] cin_r [4];
  logic [COORD_BITS-1:0] org_r [4];
  logic [COORD_BITS-1:0] pri_r [4];
  logic [1:0]            valid_r;
  logic                  owned_r, cancel_r;
  cm_t                   cm_r  [12];

  // Datapath
  logic signed [ACC_W-1:0] acc_r, acc_nxt, acc_add;
  logic                    acc_clr, acc_hi;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [GAP_W-1:0]        cur_gap_r, cur_gap_nxt, gas_r, gas_nxt;
  logic [GAP_W-1:0]        len_f_r, len_f_nxt, m_len_r, m_len_nxt;
  logic [MAG_W-1:0]        mag_r, mag_nxt;
  logic [HALF_W-1:0]       t_hi_r, t_hi_nxt;

  // Shared iterative unit
  logic [SQ_IN_W-1:0] u_v_r, u_v_nxt, u_r_r, u_r_nxt, u_b_r, u_b_nxt;
  logic [SQ_IN_W-1:0] sq_sum, sq_v_it, sq_r_it;
  logic [GAP_W:0]     rem_sh, rem_new;
  logic               div_ge;
  logic [DIV_W-1:0]   div_v_it;
  logic [GAP_W-1:0]   root;

  // Output
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_state_r, out_state_nxt, res_state_r, res_state_nxt;
  logic [15:0] out_ratio_r, out_ratio_nxt, res_ratio_r, res_ratio_nxt;

  logic                  accept;
  logic [1:0]            in_valid_bits;
  logic [COORD_BITS-1:0] cin [4];
  diff_t gx, gy, fx, fy, dx, dy;
  logic                  sq_last, div_last;
  logic [GAP_W-1:0]      gap_diff;
  logic [DIV_W-1:0]      quot;

  function automatic diff_t cm_sub(input cm_t a, input cm_t b);
    cm_sub = $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_PAD_WIDTH:  prdata = {16'd0, pad_w_r};
      REG_PAD_HEIGHT: prdata = {16'd0, pad_h_r};
      REG_GAP_MIN:    prdata = {16'd0, gap_min_r};
      REG_MOVE_MIN:   prdata = {16'd0, move_min_r};
      REG_DIR_COS:    prdata = {17'd0, dir_cos_r};
      default:        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_w_r    <= 16'd2560;
      pad_h_r    <= 16'd2560;
      gap_min_r  <= 16'd33;
      move_min_r <= 16'd328;
      dir_cos_r  <= 15'd28378;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_PAD_WIDTH:  pad_w_r    <= pwdata[15:0];
        REG_PAD_HEIGHT: pad_h_r    <= pwdata[15:0];
        REG_GAP_MIN:    gap_min_r  <= pwdata[15:0];
        REG_MOVE_MIN:   move_min_r <= pwdata[15:0];
        REG_DIR_COS:    dir_cos_r  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  assign in_ready          = (state_r == ST_IDLE);
  assign accept            = in_valid && in_ready;
  assign out_valid         = out_valid_r;
  assign out_gesture_state = out_state_r;
  assign out_gap_ratio_q8  = out_ratio_r;
  assign in_valid_bits     = {in_second_valid, in_first_valid};
  assign cin[0] = in_first_x;
  assign cin[1] = in_first_y;
  assign cin[2] = in_second_x;
  assign cin[3] = in_second_y;

  // cm_r holds current positions [0..3], origins [4..7], prior positions [8..11].
  assign gx = cm_sub(cm_r[0], cm_r[2]);
  assign gy = cm_sub(cm_r[1], cm_r[3]);
  assign fx = cm_sub(cm_r[4], cm_r[6]);
  assign fy = cm_sub(cm_r[5], cm_r[7]);
  assign dx = touch_r ? cm_sub(cm_r[2], cm_r[10]) : cm_sub(cm_r[0], cm_r[8]);
  assign dy = touch_r ? cm_sub(cm_r[3], cm_r[11]) : cm_sub(cm_r[1], cm_r[9]);

  // ---------------- shared multiplier-accumulator ----------------
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    acc_clr = 1'b0;
    acc_hi  = 1'b0;
    case (state_r)
      ST_CONV: begin
        case (k_r[3:2])
          2'd0:    mul_a = MUL_W'(cin_r[k_r[1:0]]);
          2'd1:    mul_a = MUL_W'(org_r[k_r[1:0]]);
          default: mul_a = MUL_W'(pri_r[k_r[1:0]]);
        endcase
        mul_b = MUL_W'(k_r[0] ? pad_h_r : pad_w_r);
      end
      ST_GAP_SQ: begin
        mul_a   = MUL_W'(k_r[0] ? gy : gx);
        mul_b   = mul_a;
        acc_clr = !k_r[0];
      end
      ST_F_SQ: begin
        mul_a   = MUL_W'(k_r[0] ? fy : fx);
        mul_b   = mul_a;
        acc_clr = !k_r[0];
      end
      ST_M_SQ: begin
        mul_a   = MUL_W'(k_r[0] ? dy : dx);
        mul_b   = mul_a;
        acc_clr = !k_r[0];
      end
      ST_DOT: begin
        mul_a   = MUL_W'(k_r[0] ? dy : dx);
        mul_b   = MUL_W'(k_r[0] ? fy : fx);
        acc_clr = !k_r[0];
      end
      ST_RHS: begin
        // cos * |motion|, then that 36-bit product times |axis| in two halves.
        acc_clr = (k_r != K_W'(2));
        if (k_r == K_W'(0)) begin
          mul_a = MUL_W'(dir_cos_r);
          mul_b = MUL_W'(m_len_r);
        end else if (k_r == K_W'(1)) begin
          mul_a = MUL_W'(acc_r[HALF_W-1:0]);
          mul_b = MUL_W'(len_f_r);
        end else begin
          mul_a  = MUL_W'(t_hi_r);
          mul_b  = MUL_W'(len_f_r);
          acc_hi = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign acc_add = acc_hi ? (ACC_W'(prod) <<< HALF_W) : ACC_W'(prod);
  assign acc_nxt = (acc_clr ? '0 : acc_r) + acc_add;

  // ---------------- shared sqrt / divide step ----------------
  assign sq_sum  = u_r_r + u_b_r;
  assign sq_v_it = (u_v_r >= sq_sum) ? (u_v_r - sq_sum) : u_v_r;
  assign sq_r_it = (u_v_r >= sq_sum) ? ((u_r_r >> 1) + u_b_r) : (u_r_r >> 1);
  assign root    = sq_r_it[GAP_W-1:0];
  assign sq_last = (k_r == K_W'(SQ_ITERS));

  assign rem_sh   = {u_r_r[GAP_W-1:0], u_v_r[DIV_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, gas_r});
  assign rem_new  = div_ge ? (rem_sh - {1'b0, gas_r}) : rem_sh;
  assign div_v_it = {u_v_r[DIV_W-2:0], div_ge};
  assign div_last = (k_r == K_W'(DIV_W));
  assign quot     = div_v_it;

  assign gap_diff = (len_f_r > cur_gap_r) ? (len_f_r - cur_gap_r) : (cur_gap_r - len_f_r);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r + K_W'(1);
    phase_nxt     = phase_r;
    touch_nxt     = touch_r;
    cur_gap_nxt   = cur_gap_r;
    gas_nxt       = gas_r;
    len_f_nxt     = len_f_r;
    m_len_nxt     = m_len_r;
    mag_nxt       = mag_r;
    t_hi_nxt      = t_hi_r;
    u_v_nxt       = u_v_r;
    u_r_nxt       = u_r_r;
    u_b_nxt       = u_b_r;
    res_state_nxt = res_state_r;
    res_ratio_nxt = res_ratio_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_state_nxt = out_state_r;
    out_ratio_nxt = out_ratio_r;

    // Square-root iterations share the *_RT states: load, then one bit per cycle.
    if (state_r == ST_GAP_RT || state_r == ST_F_RT || state_r == ST_M_RT) begin
      if (k_r == K_W'(0)) begin
        u_v_nxt = acc_r[SQ_IN_W-1:0];
        u_r_nxt = '0;
        u_b_nxt = SQ_IN_W'(1) << (SQ_IN_W - 2);
      end else begin
        u_v_nxt = sq_v_it;
        u_r_nxt = sq_r_it;
        u_b_nxt = u_b_r >> 2;
      end
    end

    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        touch_nxt = 1'b0;
        if (accept) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (k_r == K_W'(11)) begin
          state_nxt = ST_GAP_SQ;
          k_nxt = '0;
        end
      end
      ST_GAP_SQ, ST_F_SQ, ST_M_SQ, ST_DOT: begin
        if (k_r[0]) begin
          k_nxt = '0;
          case (state_r)
            ST_GAP_SQ: state_nxt = ST_GAP_RT;
            ST_F_SQ:   state_nxt = ST_F_RT;
            ST_M_SQ:   state_nxt = ST_M_CHK;
            default:   state_nxt = ST_RHS;
          endcase
        end
      end
      ST_GAP_RT: begin
        if (sq_last) begin
          cur_gap_nxt = root;
          k_nxt = '0;
          if (phase_r) begin
            if (cancel_r) begin
              res_state_nxt = GS_CANCEL;
              res_ratio_nxt = RATIO_ONE;
              phase_nxt = 1'b0;
              state_nxt = ST_EMIT;
            end else if (valid_r != 2'b11) begin
              res_state_nxt = GS_END;
              res_ratio_nxt = RATIO_ONE;
              phase_nxt = 1'b0;
              state_nxt = ST_EMIT;
            end else begin
              res_state_nxt = GS_RUN;
              res_ratio_nxt = RATIO_MAX;
              state_nxt = (gas_r == '0) ? ST_EMIT : ST_DIV;
            end
          end else if (valid_r == 2'b11 && !owned_r) begin
            state_nxt = ST_F_SQ;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_F_RT: begin
        if (sq_last) begin
          len_f_nxt = root;
          k_nxt = '0;
          state_nxt = ST_M_SQ;
        end
      end
      ST_M_CHK: begin
        k_nxt = '0;
        // A touch below the motion threshold is not moving and passes.
        if (acc_r < $signed(ACC_W'({move_min_r, 8'd0}))) begin
          touch_nxt = 1'b1;
          state_nxt = touch_r ? ST_DIFF : ST_M_SQ;
        end else begin
          state_nxt = ST_M_RT;
        end
      end
      ST_M_RT: begin
        if (sq_last) begin
          m_len_nxt = root;
          k_nxt = '0;
          state_nxt = ST_DOT;
        end
      end
      ST_RHS: begin
        if (k_r == K_W'(0)) begin
          mag_nxt = acc_r[ACC_W-1] ? MAG_W'(-acc_r) : MAG_W'(acc_r);
        end
        if (k_r == K_W'(1)) t_hi_nxt = acc_r[2*HALF_W-1:HALF_W];
        if (k_r == K_W'(2)) begin
          k_nxt = '0;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        k_nxt = '0;
        if ({3'd0, mag_r, 15'd0} >= acc_r[ACC_W-1:0]) begin
          touch_nxt = 1'b1;
          state_nxt = touch_r ? ST_DIFF : ST_M_SQ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIFF: begin
        k_nxt = '0;
        if (gap_diff >= GAP_W'({gap_min_r, 4'd0})) begin
          gas_nxt = cur_gap_r;
          phase_nxt = 1'b1;
          res_state_nxt = GS_START;
          res_ratio_nxt = RATIO_MAX;
          state_nxt = (cur_gap_r == '0) ? ST_EMIT : ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (k_r == K_W'(0)) begin
          u_v_nxt = SQ_IN_W'({cur_gap_r, {RATIO_FRAC_BITS{1'b0}}});
          u_r_nxt = '0;
        end else begin
          u_v_nxt = SQ_IN_W'(div_v_it);
          u_r_nxt = SQ_IN_W'(rem_new[GAP_W-1:0]);
        end
        if (div_last) begin
          res_ratio_nxt = (quot > DIV_W'(RATIO_MAX)) ? RATIO_MAX : quot[15:0];
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_state_nxt = res_state_r;
          out_ratio_nxt = res_ratio_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= '0;
      phase_r      <= 1'b0;
      touch_r      <= 1'b0;
      prev_valid_r <= 2'b00;
      gas_r        <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        org_r[i] <= '0;
        pri_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      phase_r     <= phase_nxt;
      touch_r     <= touch_nxt;
      gas_r       <= gas_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        prev_valid_r <= in_valid_bits;
        // A touch going down latches its origin and seeds its prior position.
        for (int t = 0; t < 2; t++) begin
          if (in_valid_bits[t] && !prev_valid_r[t]) begin
            org_r[2*t]   <= cin[2*t];
            org_r[2*t+1] <= cin[2*t+1];
            pri_r[2*t]   <= cin[2*t];
            pri_r[2*t+1] <= cin[2*t+1];
          end
        end
      end
      // Prior positions are already converted once the last conversion is done.
      if (state_r == ST_CONV && k_r == K_W'(11)) begin
        for (int t = 0; t < 2; t++) begin
          if (valid_r[t]) begin
            pri_r[2*t]   <= cin_r[2*t];
            pri_r[2*t+1] <= cin_r[2*t+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) cin_r[i] <= cin[i];
      valid_r  <= in_valid_bits;
      owned_r  <= in_touch_owned;
      cancel_r <= in_cancel;
    end
    if (state_r == ST_CONV) cm_r[k_r[3:0]] <= prod[CONV_SHIFT +: CM_W];
    acc_r       <= acc_nxt;
    cur_gap_r   <= cur_gap_nxt;
    len_f_r     <= len_f_nxt;
    m_len_r     <= m_len_nxt;
    mag_r       <= mag_nxt;
    t_hi_r      <= t_hi_nxt;
    u_v_r       <= u_v_nxt;
    u_r_r       <= u_r_nxt;
    u_b_r       <= u_b_nxt;
    res_state_r <= res_state_nxt;
    res_ratio_r <= res_ratio_nxt;
    out_state_r <= out_state_nxt;
    out_ratio_r <= out_ratio_nxt;
  end

  // ---------------- assertions ----------------
  a_end_ratio_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gesture_state == GS_END || out_gesture_state == GS_CANCEL)
    |-> out_gap_ratio_q8 == RATIO_ONE)
    else $error("ending or canceled result without unit ratio");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("ready right after a frame was taken");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_EMIT))
    else $error("result raised outside the emit step");

  a_start_sets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && res_state_nxt == GS_START |-> phase_r)
    else $error("start result while the gesture is not active");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pinch recognizer: directed and random touch
// frames and register settings, an in-bench prediction of state and gap
// ratio, and an in-order comparison of every result transaction.
// ----------------------------------------------------------------------------

class pinch_scoreboard;
  logic [15:0] width_q8, height_q8, gap_min_q8, move_min_q16;
  logic [14:0] cos_q15;
  bit          pinch_on;
  logic [11:0] origin[4];
  logic [11:0] last_pos[4];
  longint unsigned pinch_gap;
  logic [1:0]  last_down;
  logic [1:0]  state_q[$];
  logic [15:0] ratio_q[$];
  int          errors;

  function void clear();
    width_q8 = 16'd2560; height_q8 = 16'd2560; gap_min_q8 = 16'd33;
    move_min_q16 = 16'd328; cos_q15 = 15'd28378;
    pinch_on = 0; pinch_gap = 0; last_down = 2'b00;
    for (int i = 0; i < 4; i++) begin
      origin[i] = '0;
      last_pos[i] = '0;
    end
    state_q.delete(); ratio_q.delete(); errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      pgr_pkg::REG_PAD_WIDTH:  width_q8 = val[15:0];
      pgr_pkg::REG_PAD_HEIGHT: height_q8 = val[15:0];
      pgr_pkg::REG_GAP_MIN:    gap_min_q8 = val[15:0];
      pgr_pkg::REG_MOVE_MIN:   move_min_q16 = val[15:0];
      pgr_pkg::REG_DIR_COS:    cos_q15 = val[14:0];
      default: ;
    endcase
  endfunction

  function longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function longint scale_cm(logic [11:0] c, logic [15:0] size);
    longint unsigned prod;
    prod = longint'(c) * longint'(size);
    return longint'(prod >> 8);
  endfunction

  function longint unsigned sq_sum(longint x, longint y);
    return longint'(x * x) + longint'(y * y);
  endfunction

  function bit along_axis(longint dx, longint dy, longint ax, longint ay);
    longint unsigned dsq, mag;
    longint dot;
    dsq = sq_sum(dx, dy);
    if (dsq < (longint'(move_min_q16) << 8)) return 1;
    dot = dx * ax + dy * ay;
    mag = (dot < 0) ? -dot : dot;
    return (mag << 15) >= longint'(cos_q15) * floor_sqrt(dsq) * floor_sqrt(sq_sum(ax, ay));
  endfunction

  function logic [15:0] ratio_of(longint unsigned cur);
    longint unsigned q;
    if (pinch_gap == 0) return 16'hFFFF;
    q = (cur << 8) / pinch_gap;
    return (q > 65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Notes one accepted touch frame and queues the result it causes, if any.
  function void note_frame(logic [11:0] pos[4], logic [1:0] down, bit owned, bit cxl);
    longint p[4], o[4], q[4];
    longint unsigned cur, base, diff;
    longint ax, ay;
    for (int t = 0; t < 2; t++)
      if (down[t] && !last_down[t]) begin
        origin[2*t] = pos[2*t]; last_pos[2*t] = pos[2*t];
        origin[2*t+1] = pos[2*t+1]; last_pos[2*t+1] = pos[2*t+1];
      end
    for (int i = 0; i < 4; i++) begin
      p[i] = scale_cm(pos[i], (i & 1) ? height_q8 : width_q8);
      o[i] = scale_cm(origin[i], (i & 1) ? height_q8 : width_q8);
      q[i] = scale_cm(last_pos[i], (i & 1) ? height_q8 : width_q8);
    end
    cur = floor_sqrt(sq_sum(p[0] - p[2], p[1] - p[3]));
    if (pinch_on) begin
      if (cxl) begin
        state_q.push_back(pgr_pkg::GS_CANCEL); ratio_q.push_back(16'd256); pinch_on = 0;
      end else if (down != 2'b11) begin
        state_q.push_back(pgr_pkg::GS_END); ratio_q.push_back(16'd256); pinch_on = 0;
      end else begin
        state_q.push_back(pgr_pkg::GS_RUN); ratio_q.push_back(ratio_of(cur));
      end
    end else if (down == 2'b11 && !owned) begin
      ax = o[0] - o[2];
      ay = o[1] - o[3];
      if (along_axis(p[0] - q[0], p[1] - q[1], ax, ay) &&
          along_axis(p[2] - q[2], p[3] - q[3], ax, ay)) begin
        base = floor_sqrt(sq_sum(ax, ay));
        diff = (base > cur) ? base - cur : cur - base;
        if (diff >= (longint'(gap_min_q8) << 4)) begin
          pinch_gap = cur & 64'hFFFFFF;
          state_q.push_back(pgr_pkg::GS_START); ratio_q.push_back(ratio_of(cur));
          pinch_on = 1;
        end
      end
    end
    for (int t = 0; t < 2; t++)
      if (down[t]) begin
        last_pos[2*t] = pos[2*t];
        last_pos[2*t+1] = pos[2*t+1];
      end
    last_down = down;
  endfunction

  task report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(logic [1:0] st, logic [15:0] ratio);
    logic [1:0] want_st;
    logic [15:0] want_ratio;
    if (state_q.size() == 0) begin
      report("unexpected result transaction, state", st, -1);
      return;
    end
    want_st = state_q.pop_front();
    want_ratio = ratio_q.pop_front();
    if (st !== want_st) report("gesture_state", st, want_st);
    if (ratio !== want_ratio) report("gap_ratio_q8", ratio, want_ratio);
  endtask
endclass

module tb_top;
  import pgr_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_first_x = '0, in_first_y = '0, in_second_x = '0, in_second_y = '0;
  logic        in_first_valid = 1'b0, in_second_valid = 1'b0;
  logic        in_touch_owned = 1'b0, in_cancel = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_gesture_state;
  logic [15:0] out_gap_ratio_q8;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pinch_scoreboard frames_sb;
  bit   rx_hold_long = 0;
  bit   drain_done = 0;
  int   idle_cycles = 0;
  // Finger tracks for well-formed gestures.
  logic [11:0] trk[4];
  logic [1:0]  trk_down;

  pinch_gesture_recognizer i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (out_valid && out_ready)
      frames_sb.check_result(out_gesture_state, out_gap_ratio_q8);
  end

  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (rx_hold_long) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        rx_hold_long = 0;
      end
      n = gap_len();
      if ((n > 0) && ($urandom_range(0, 3) != 0)) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || drain_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    frames_sb.set_reg(idx, val);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_frame(logic [11:0] fx, logic [11:0] fy, logic [11:0] sx,
                            logic [11:0] sy, logic [1:0] down, bit owned, bit cxl);
    logic [11:0] pos[4];
    int n;
    n = gap_len();
    if ((n > 0) && ($urandom_range(0, 2) != 0)) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_first_x <= fx; in_first_y <= fy; in_second_x <= sx; in_second_y <= sy;
    in_first_valid <= down[0]; in_second_valid <= down[1];
    in_touch_owned <= owned; in_cancel <= cxl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pos[0] = fx; pos[1] = fy; pos[2] = sx; pos[3] = sy;
    frames_sb.note_frame(pos, down, owned, cxl);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (frames_sb.state_q.size() != 0) @(posedge clk);
    // Frames without a result may still be in flight.
    repeat (250) @(posedge clk);
  endtask

  function logic [11:0] step_coord(int c, int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  // One pinch-like sequence: fingers land, spread or close along their axis.
  task automatic gesture_seq();
    int steps, sp, dir;
    trk[0] = 12'($urandom_range(0, 4095)); trk[1] = 12'($urandom_range(0, 4095));
    trk[2] = 12'($urandom_range(0, 4095)); trk[3] = 12'($urandom_range(0, 4095));
    steps = $urandom_range(3, 14);
    sp = $urandom_range(1, 120);
    dir = $urandom_range(0, 1) ? 1 : -1;
    for (int k = 0; k < steps; k++) begin
      if (k > 0) begin
        trk[0] = step_coord(int'(trk[0]) + dir * ((trk[0] > trk[2]) ? sp : -sp) / 2,
                            sp / 8);
        trk[1] = step_coord(int'(trk[1]) + dir * ((trk[1] > trk[3]) ? sp : -sp) / 2,
                            sp / 8);
        trk[2] = step_coord(int'(trk[2]), sp / 4);
        trk[3] = step_coord(int'(trk[3]), sp / 4);
      end
      trk_down = 2'b11;
      if (k == steps - 1 && $urandom_range(0, 1)) trk_down = 2'($urandom_range(0, 2));
      send_frame(trk[0], trk[1], trk[2], trk[3], trk_down,
                 $urandom_range(0, 19) == 0, $urandom_range(0, 24) == 0);
    end
  endtask

  task automatic noise_frame();
    send_frame(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
               12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
               2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
  endtask

  task automatic random_config();
    for (int r = 0; r < 5; r++) begin
      case ($urandom_range(0, 3))
        0: cfg_write(r[2:0], 32'd0);
        1: cfg_write(r[2:0], (r == 4) ? 32'h7FFF : 32'hFFFF);
        default: cfg_write(r[2:0], (r == 4) ? $urandom_range(0, 32767)
                                            : $urandom_range(0, 65535));
      endcase
    end
  endtask

  initial begin
    int sent;
    frames_sb = new();
    frames_sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at reset settings.
    send_frame(12'd0, 12'd0, 12'd0, 12'd0, 2'b11, 0, 0);
    send_frame(12'd0, 12'd0, 12'd4095, 12'd4095, 2'b11, 0, 0);
    send_frame(12'd100, 12'd100, 12'd200, 12'd200, 2'b00, 0, 0);
    send_frame(12'd100, 12'd100, 12'd200, 12'd200, 2'b11, 0, 0);
    send_frame(12'd50, 12'd50, 12'd250, 12'd250, 2'b11, 0, 1);
    send_frame(12'd10, 12'd10, 12'd4000, 12'd4000, 2'b11, 0, 0);
    send_frame(12'd0, 12'd0, 12'd4095, 12'd4095, 2'b11, 0, 0);
    send_frame(12'd0, 12'd0, 12'd4095, 12'd4095, 2'b01, 0, 1);
    send_frame(12'd2000, 12'd2000, 12'd2000, 12'd2000, 2'b11, 0, 0);
    send_frame(12'd1000, 12'd1000, 12'd3000, 12'd3000, 2'b11, 1, 0);
    send_frame(12'd1000, 12'd1000, 12'd3000, 12'd3000, 2'b11, 0, 0);
    send_frame(12'd1100, 12'd1100, 12'd2900, 12'd2900, 2'b11, 0, 0);
    send_frame(12'd1100, 12'd1100, 12'd2900, 12'd2900, 2'b10, 0, 0);
    send_frame(12'd4095, 12'd0, 12'd0, 12'd4095, 2'b11, 0, 0);
    send_frame(12'd4095, 12'd4095, 12'd4095, 12'd4095, 2'b11, 0, 0);
    send_frame(12'd4095, 12'd4095, 12'd4095, 12'd4095, 2'b00, 0, 0);
    wait_drained();
    cfg_write(REG_GAP_MIN, 32'd0);
    cfg_write(REG_DIR_COS, 32'h7FFF);
    send_frame(12'd5, 12'd5, 12'd5, 12'd5, 2'b11, 0, 0);
    send_frame(12'd5, 12'd5, 12'd5, 12'd5, 2'b11, 0, 0);
    send_frame(12'd5, 12'd5, 12'd9, 12'd5, 2'b11, 0, 1);
    wait_drained();

    sent = 0;
    for (int phase_no = 0; phase_no < 10; phase_no++) begin
      if (phase_no == 0) begin
        cfg_write(REG_PAD_WIDTH, 32'd2560); cfg_write(REG_PAD_HEIGHT, 32'd2560);
        cfg_write(REG_GAP_MIN, 32'd33); cfg_write(REG_MOVE_MIN, 32'd328);
        cfg_write(REG_DIR_COS, 32'd28378);
      end else begin
        random_config();
        if (phase_no == 9) begin
          cfg_write(REG_PAD_WIDTH, 32'hFFFF); cfg_write(REG_PAD_HEIGHT, 32'hFFFF);
          cfg_write(REG_MOVE_MIN, 32'hFFFF);
        end
      end
      if (phase_no == 3) rx_hold_long = 1;
      while (sent < (phase_no + 1) * 153) begin
        if ($urandom_range(0, 4) == 0) begin
          noise_frame();
          sent++;
        end else begin
          gesture_seq();
          sent += 8;
        end
      end
      if (phase_no == 5) begin
        // Let every outstanding result arrive before going on.
        while (frames_sb.state_q.size() != 0) @(posedge clk);
      end
      wait_drained();
    end

    drain_done = 1;
    if (frames_sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule
